@@ src/lut_waveform_generator_macros.svh @@
// ----------------------------------------------------------------------------
// lut_waveform_generator_macros.svh
// assertion macros used by the waveform generator top-level source
// ----------------------------------------------------------------------------
`ifndef LUT_WAVEFORM_GENERATOR_MACROS_SVH
`define LUT_WAVEFORM_GENERATOR_MACROS_SVH

// same-cycle implication, held off while reset is low
`define LWG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwg implication check failed");

// next-cycle implication, held off while reset is low
`define LWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwg next-cycle check failed");

`endif

@@ src/lwg_pkg.sv @@
// ----------------------------------------------------------------------------
// lwg_pkg
// types, constants and the quarter-wave table of the waveform generator
// ----------------------------------------------------------------------------
package lwg_pkg;

    // field and datapath widths
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 16;
    localparam int AMP_W      = 12;
    localparam int DUTY_W     = 10;
    localparam int SAMPLE_W   = 12;
    localparam int DIV_W      = 16;
    localparam int VAL_W      = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    // default full-scale dac code
    localparam int DAC_MAX_DEF = 4095;

    // arithmetic constants
    localparam int DUTY_FULL   = 1000;
    localparam int SINE_STEPS  = 256;
    localparam int SINE_SCALE  = 32768;

    // register reset values
    localparam logic [IDX_W-1:0]  COUNT_RST = IDX_W'(256);
    localparam logic [DUTY_W-1:0] DUTY_RST  = DUTY_W'(500);

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WAVE_KIND    = 3'd0,
        REG_SAMPLE_COUNT = 3'd1,
        REG_AMPLITUDE    = 3'd2,
        REG_OFFSET       = 3'd3,
        REG_DUTY         = 3'd4
    } t_cfg_reg;

    // waveform kinds
    typedef enum logic [KIND_W-1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SAW    = 2'd3
    } t_wave;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN1,
        ST_ROM,
        ST_RUN2,
        ST_FIN
    } t_state;

    // request to the serial multiply-divide unit: q = a * m / d
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] a;
        logic [DIV_W-1:0] m;
        logic [DIV_W-1:0] d;
    } t_div_req;

    // status of the serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // quarter period of a sine, full scale 32767
    localparam logic [15:0] QUARTER_ROM [64] = '{
        16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4012,  16'd4808,  16'd5602,
        16'd6393,  16'd7180,  16'd7962,  16'd8739,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
        16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
        16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
        16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
        16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
        16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
        16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758
    };

endpackage

@@ src/lut_waveform_generator.sv @@
// ----------------------------------------------------------------------------
// lut_waveform_generator
// one dac sample of a sine, square, triangle or sawtooth period per beat
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata[0] restart
//  m_axis    | out       | tdata sample, sample_index; tlast last point of period
//  cfg       | in        | register writes, index in i_cfg_addr
//
//  square, triangle and sawtooth show the result after one pass of a bit-serial
//  multiply-divide unit, sine after a second pass: the unit works through
//  16 multiplier bits, once for the phase and once more for sine scaling.
//  one item is in flight at a time, so an input beat is taken only once the last
//  result is in the output register; a new beat is taken while a result waits.
//  a stalled result holds the sequencer before the output register.
//  synchronous active-low reset; no clearing pass.
`include "lut_waveform_generator_macros.svh"

module lut_waveform_generator
    import lwg_pkg::*;
#(
    parameter int DAC_MAX = DAC_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beat
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [0] restart, rest zero
    // result beat
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [11:0] sample, [27:12] sample_index
    output logic                  o_m_axis_tlast,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam logic signed [VAL_W-1:0] DAC_MAX_S = VAL_W'(DAC_MAX);
    localparam int PAD_W = M_TDATA_W - SAMPLE_W - IDX_W;

    // configuration registers
    t_wave              r_kind;
    logic [IDX_W-1:0]   r_count;
    logic [AMP_W-1:0]   r_amp;
    logic [AMP_W-1:0]   r_offset;
    logic [DUTY_W-1:0]  r_duty;

    // sequencer and per-item state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_i;
    logic               r_neg;

    // output register
    logic               r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [IDX_W-1:0]   r_out_index;
    logic               r_out_last;

    // serial unit
    t_div_req           div_req;
    t_div_stat          div_stat;
    logic [DIV_W-1:0]   div_q;

    logic               s_acc;
    logic               out_load;
    logic [IDX_W-1:0]   n_eff;
    logic [IDX_W-1:0]   i_cur;
    logic [IDX_W:0]     i_inc;
    logic [5:0]         rom_idx;
    logic [15:0]        rom_val;

    logic signed [VAL_W-1:0] offs_s, half_s, hi, lo, lo_raw, hi_raw, span, q_s;
    logic signed [VAL_W-1:0] v_raw, v_tri, v_clamp;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= WAVE_SINE;
            r_count  <= COUNT_RST;
            r_amp    <= '0;
            r_offset <= '0;
            r_duty   <= DUTY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WAVE_KIND:    r_kind   <= t_wave'(i_cfg_wdata[KIND_W-1:0]);
                REG_SAMPLE_COUNT: r_count  <= i_cfg_wdata[IDX_W-1:0];
                REG_AMPLITUDE:    r_amp    <= i_cfg_wdata[AMP_W-1:0];
                REG_OFFSET:       r_offset <= i_cfg_wdata[AMP_W-1:0];
                REG_DUTY:         r_duty   <= i_cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // period length and levels, from config alone
    always_comb begin
        n_eff  = (r_count == '0) ? IDX_W'(1) : r_count;
        offs_s = $signed({{(VAL_W-AMP_W){1'b0}}, r_offset});
        half_s = $signed({{(VAL_W-AMP_W+1){1'b0}}, r_amp[AMP_W-1:1]});
        hi_raw = offs_s + half_s;
        hi     = (hi_raw > DAC_MAX_S) ? DAC_MAX_S : hi_raw;
        lo_raw = offs_s - half_s;
        lo     = (lo_raw < 0) ? '0 : lo_raw;
        span   = (hi > lo) ? (hi - lo) : '0;
    end

    // index of the accepted beat and its successor
    always_comb begin
        i_cur = (i_s_axis_tdata[0] || (r_idx >= n_eff)) ? '0 : r_idx;
        i_inc = {1'b0, i_cur} + 1'b1;
    end

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // quarter-wave mirror on the phase from the first pass
    assign rom_idx = div_q[6] ? ~div_q[5:0] : div_q[5:0];
    assign rom_val = QUARTER_ROM[rom_idx];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_acc) n_state = ST_LOAD;
            ST_LOAD: n_state = ST_RUN1;
            ST_RUN1: begin
                if (div_stat.done) n_state = (r_kind == WAVE_SINE) ? ST_ROM : ST_FIN;
            end
            ST_ROM:  n_state = ST_RUN2;
            ST_RUN2: if (div_stat.done) n_state = ST_FIN;
            ST_FIN:  if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs: ready, unit request, result load
    always_comb begin
        o_s_axis_tready = 1'b0;
        out_load        = 1'b0;
        div_req.start   = 1'b0;
        div_req.a       = r_i;
        div_req.m       = DIV_W'(SINE_STEPS);
        div_req.d       = n_eff;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_LOAD: begin
                div_req.start = 1'b1;
                case (r_kind)
                    WAVE_SQUARE: begin
                        div_req.a = {{(DIV_W-DUTY_W){1'b0}}, r_duty};
                        div_req.m = n_eff;
                        div_req.d = DIV_W'(DUTY_FULL);
                    end
                    WAVE_TRI: div_req.m = {span[DIV_W-2:0], 1'b0};
                    WAVE_SAW: div_req.m = span[DIV_W-1:0];
                    default:  div_req.m = DIV_W'(SINE_STEPS);
                endcase
            end
            ST_ROM: begin
                div_req.start = 1'b1;
                div_req.a     = rom_val;
                div_req.m     = {{(DIV_W-AMP_W){1'b0}}, r_amp};
                div_req.d     = DIV_W'(SINE_SCALE);
            end
            ST_FIN:  out_load = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    // sequencer and index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_idx <= (i_inc >= {1'b0, n_eff}) ? '0 : i_inc[IDX_W-1:0];
            end
        end
    end

    // per-item payload
    always_ff @(posedge i_clk) begin
        if (s_acc) r_i <= i_cur;
        if (r_state == ST_ROM) r_neg <= div_q[7];
    end

    lwg_serdiv u_serdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat),
        .o_q     (div_q)
    );

    // final level per wave kind, then clamp to the dac range
    always_comb begin
        q_s   = $signed({{(VAL_W-DIV_W){1'b0}}, div_q});
        v_tri = lo + q_s;
        case (r_kind)
            WAVE_SQUARE: begin
                v_raw = ((r_duty >= DUTY_W'(DUTY_FULL)) || (r_i < div_q)) ? hi : lo;
            end
            WAVE_TRI: v_raw = (v_tri > hi) ? ((hi <<< 1) - v_tri) : v_tri;
            WAVE_SAW: v_raw = lo + q_s;
            default:  v_raw = r_neg ? (offs_s - q_s) : (offs_s + q_s);
        endcase
        if (v_raw < 0) begin
            v_clamp = '0;
        end else if (v_raw > DAC_MAX_S) begin
            v_clamp = DAC_MAX_S;
        end else begin
            v_clamp = v_raw;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= v_clamp[SAMPLE_W-1:0];
            r_out_index  <= r_i;
            r_out_last   <= (r_i == (n_eff - 1'b1));
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_index, r_out_sample};
    assign o_m_axis_tlast  = r_out_last;

    // checks on the sequencer, serial unit and result
    `LWG_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, s_acc, r_state == ST_LOAD)
    `LWG_ASSERT_IMPLY(a_idle_unit_quiet, i_clk, i_rst_n,
        r_state == ST_IDLE || r_state == ST_FIN, !div_stat.busy)
    `LWG_ASSERT_IMPLY(a_index_in_period, i_clk, i_rst_n,
        r_out_valid, r_out_index < n_eff)
    `LWG_ASSERT_IMPLY(a_last_at_end, i_clk, i_rst_n,
        r_out_valid && r_out_last, r_out_index == (n_eff - 1'b1))

endmodule

@@ src/lwg_serdiv.sv @@
// ----------------------------------------------------------------------------
// lwg_serdiv
// bit-serial scaled multiply-divide, q = floor(a * m / d) for a < d
// ----------------------------------------------------------------------------
module lwg_serdiv
    import lwg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output t_div_stat        o_stat,
    output logic [DIV_W-1:0] o_q
);

    localparam int CNT_W = $clog2(DIV_W);

    // control
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // operands and partial results; m shifts out msb first
    logic [DIV_W-1:0] r_a, r_d, r_m, r_r, r_q;
    logic [DIV_W-1:0] n_a, n_d, n_m, n_r, n_q;

    logic [DIV_W:0]   dbl, dbl_sub, sum, sum_sub;
    logic             dbl_ge, sum_ge;

    // doubling step and add step, one compare-subtract each
    always_comb begin
        dbl     = {r_r, 1'b0};
        dbl_sub = dbl - {1'b0, r_d};
        dbl_ge  = dbl >= {1'b0, r_d};
        sum     = {1'b0, r_r} + (r_m[DIV_W-1] ? {1'b0, r_a} : '0);
        sum_sub = sum - {1'b0, r_d};
        sum_ge  = sum >= {1'b0, r_d};
    end

    // next values
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_d     = r_d;
        n_m     = r_m;
        n_r     = r_r;
        n_q     = r_q;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_cnt   = '0;
            n_a     = i_req.a;
            n_d     = i_req.d;
            n_m     = i_req.m;
            n_r     = '0;
            n_q     = '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                n_r     = dbl_ge ? dbl_sub[DIV_W-1:0] : dbl[DIV_W-1:0];
                n_q     = {r_q[DIV_W-2:0], dbl_ge};
                n_phase = 1'b1;
            end else begin
                n_r     = sum_ge ? sum_sub[DIV_W-1:0] : sum[DIV_W-1:0];
                n_q     = r_q + {{(DIV_W-1){1'b0}}, sum_ge};
                n_m     = {r_m[DIV_W-2:0], 1'b0};
                n_phase = 1'b0;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W-1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_d <= n_d;
        r_m <= n_m;
        r_r <= n_r;
        r_q <= n_q;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_q         = r_q;

endmodule

@@ verif/lut_waveform_generator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_waveform_generator_checker
// watches the register writes and both stream channels of the waveform
// generator, forms the sample due for every accepted input beat and compares
// each result beat with the oldest sample still due
// ----------------------------------------------------------------------------
module lut_waveform_generator_checker
    import lwg_pkg::*;
#(
    parameter int DAC_MAX = DAC_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,    // [0] restart
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,    // [11:0] sample, [27:12] sample_index
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    index;
        logic                last;
    } t_wave_point;

    // samples owed by the generator, oldest first
    t_wave_point due_points[$];

    // shadow copy of the register file and the sample index
    t_wave              kind_q;
    logic [IDX_W-1:0]   count_q;
    logic [AMP_W-1:0]   amp_q;
    logic [AMP_W-1:0]   offset_q;
    logic [DUTY_W-1:0]  duty_q;
    longint             point_idx;
    int                 fail_count = 0;

    function automatic longint clamp_dac(longint v);
        if (v < 0) return 0;
        if (v > DAC_MAX) return DAC_MAX;
        return v;
    endfunction

    // dac code of point pos in a period of n points
    function automatic logic [SAMPLE_W-1:0] level_at(longint pos, longint n);
        longint half;
        longint hi;
        longint lo;
        longint span;
        longint v;
        longint phase;
        longint rom_val;
        half = longint'(amp_q) / 2;
        hi   = clamp_dac(longint'(offset_q) + half);
        lo   = longint'(offset_q) - half;
        if (lo < 0) lo = 0;
        span = (hi > lo) ? hi - lo : 0;
        case (kind_q)
            WAVE_SQUARE: begin
                v = (pos < (n * longint'(duty_q)) / DUTY_FULL) ? hi : lo;
            end
            WAVE_TRI: begin
                v = (pos * 2 * span) / n + lo;
                // fold back down past the peak
                if (v > hi) v = 2 * hi - v;
            end
            WAVE_SAW: begin
                v = lo + (pos * span) / n;
            end
            default: begin
                // mirror the quarter table over the four quadrants
                phase = ((pos * SINE_STEPS) / n) % SINE_STEPS;
                if (phase < 64) rom_val = QUARTER_ROM[phase];
                else if (phase < 128) rom_val = QUARTER_ROM[127 - phase];
                else if (phase < 192) rom_val = -longint'(QUARTER_ROM[phase - 128]);
                else rom_val = -longint'(QUARTER_ROM[255 - phase]);
                // signed division truncates toward zero
                v = longint'(offset_q) + (rom_val * longint'(amp_q)) / SINE_SCALE;
            end
        endcase
        return SAMPLE_W'(clamp_dac(v));
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_wave_point want;
        longint      n;
        if (!i_rst_n) begin
            kind_q    = WAVE_SINE;
            count_q   = COUNT_RST;
            amp_q     = '0;
            offset_q  = '0;
            duty_q    = DUTY_RST;
            point_idx = 0;
            due_points.delete();
        end else begin
            // result beat against the oldest sample due
            if (i_m_tvalid && i_m_tready) begin
                if (due_points.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none actual sample %0d index %0d",
                             $time, i_m_tdata[SAMPLE_W-1:0], i_m_tdata[SAMPLE_W +: IDX_W]);
                end else begin
                    want = due_points.pop_front();
                    check_field("sample", want.sample, i_m_tdata[SAMPLE_W-1:0]);
                    check_field("sample_index", want.index, i_m_tdata[SAMPLE_W +: IDX_W]);
                    check_field("last", want.last, i_m_tlast);
                end
            end

            // input beat: form the sample and step the index
            if (i_s_tvalid && i_s_tready) begin
                n = (count_q == 0) ? 1 : count_q;
                // restart, or index left outside a period that shrank
                if (i_s_tdata[0] || point_idx >= n) point_idx = 0;
                want.sample = level_at(point_idx, n);
                want.index  = IDX_W'(point_idx);
                want.last   = (point_idx == n - 1);
                due_points.push_back(want);
                point_idx = (point_idx + 1 >= n) ? 0 : point_idx + 1;
            end

            // register writes
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    REG_WAVE_KIND:    kind_q   = t_wave'(i_cfg_wdata[KIND_W-1:0]);
                    REG_SAMPLE_COUNT: count_q  = i_cfg_wdata[IDX_W-1:0];
                    REG_AMPLITUDE:    amp_q    = i_cfg_wdata[AMP_W-1:0];
                    REG_OFFSET:       offset_q = i_cfg_wdata[AMP_W-1:0];
                    REG_DUTY:         duty_q   = i_cfg_wdata[DUTY_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= due_points.size();
    end

endmodule

@@ verif/lut_waveform_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_waveform_generator_tb
// drives input beats, some with restart, through the waveform generator under all four wave
// kinds, edge and random register settings and several idle and stall
// patterns; the checker beside the block predicts and compares every sample
// ----------------------------------------------------------------------------
module lut_waveform_generator_tb;
    import lwg_pkg::*;

    localparam logic [4:0] ALL_REGS   = 5'b11111;
    localparam int         RAND_ITEMS = 1250;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    t_cfg_reg              cfg_addr  = REG_WAVE_KIND;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int beats_sent      = 0;

    lut_waveform_generator i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    lut_waveform_generator_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic write_reg(input t_cfg_reg idx, input int value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // write the registers selected in mask, then release the write port
    task automatic program_regs(input t_wave kind, input int count, input int amp,
                                input int offs, input int duty, input logic [4:0] mask);
        if (mask[REG_WAVE_KIND])    write_reg(REG_WAVE_KIND, kind);
        if (mask[REG_SAMPLE_COUNT]) write_reg(REG_SAMPLE_COUNT, count);
        if (mask[REG_AMPLITUDE])    write_reg(REG_AMPLITUDE, amp);
        if (mask[REG_OFFSET])       write_reg(REG_OFFSET, offs);
        if (mask[REG_DUTY])         write_reg(REG_DUTY, duty);
        cfg_we <= 1'b0;
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic restart);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(restart);
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    // hold the sender until every sample due has come out
    task automatic drain_samples();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic int pick_level();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(4095);
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(11))
            0:       return 0;
            1:       return 1;
            2:       return 65535;
            3:       return $urandom_range(65535);
            default: return $urandom_range(2, 300);
        endcase
    endfunction

    function automatic int pick_duty();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 1000;
            2:       return 1023;
            default: return $urandom_range(1023);
        endcase
    endfunction

    initial begin
        int phase;
        int n_beats;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: sine of zero amplitude
        repeat (2) send_beat(1'b0);
        drain_samples();

        // full-scale sine over a short period, wrap, then restart
        program_regs(WAVE_SINE, 8, 4095, 2048, 500, ALL_REGS);
        repeat (9) send_beat(1'b0);
        send_beat(1'b1);
        drain_samples();

        // duty above full scale keeps the square high, clipped at the top
        program_regs(WAVE_SQUARE, 4, 4095, 4095, 1023, ALL_REGS);
        repeat (2) send_beat(1'b0);
        drain_samples();

        // zero duty, zero count taken as a one-point period
        program_regs(WAVE_SQUARE, 0, 4095, 4095, 0, ALL_REGS);
        repeat (2) send_beat(1'b0);
        drain_samples();

        // triangle with the low level clipped at zero
        program_regs(WAVE_TRI, 5, 4095, 0, 500, ALL_REGS);
        repeat (5) send_beat(1'b0);
        drain_samples();

        // longest period, then shrink it below the running index
        program_regs(WAVE_SAW, 65535, 4095, 2048, 500, ALL_REGS);
        repeat (3) send_beat(1'b0);
        drain_samples();
        program_regs(WAVE_SAW, 2, 0, 0, 0, 5'b00010);
        repeat (2) send_beat(1'b0);
        drain_samples();

        // random settings, rotating through the idle patterns
        phase = 0;
        while (beats_sent < RAND_ITEMS + 26) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 61; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin sender_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            program_regs(t_wave'($urandom_range(3)), pick_count(), pick_level(),
                         pick_level(), pick_duty(),
                         5'($urandom_range(31)) | (5'b1 << REG_WAVE_KIND));
            n_beats = $urandom_range(20, 70);
            repeat (n_beats) begin
                if ($urandom_range(199) == 0) drain_samples();
                send_beat($urandom_range(19) == 0);
            end
            drain_samples();
            phase++;
        end

        // let any stray result show up
        repeat (100) @(posedge clk);
        if (fail_count == 0) begin
            $display("lut_waveform_generator test passed");
        end else begin
            $display("lut_waveform_generator test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("lut_waveform_generator test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/lwg_pkg.sv
src/lwg_serdiv.sv
src/lut_waveform_generator.sv
verif/lut_waveform_generator_checker.sv
verif/lut_waveform_generator_tb.sv
